// File: hdl/ird_pkg.sv
// ird_pkg: command, status and sequencer state codes plus shared constants
// for the indexed ring deque. No dependencies.
package ird_pkg;

	// default sizing, handed to the top level parameters
	localparam int CAPACITY_DEF   = 256;
	localparam int DATA_WIDTH_DEF = 32;

	// fixed field widths of the channels
	localparam int CMD_W   = 4;
	localparam int IDX_W   = 9;
	localparam int VAL_W   = 32;
	localparam int ST_W    = 2;
	localparam int COUNT_W = 9;

	typedef enum logic [CMD_W-1:0] {
		CMD_GET         = 4'd0,
		CMD_SET         = 4'd1,
		CMD_INSERT      = 4'd2,
		CMD_ERASE       = 4'd3,
		CMD_INSERT_GAP  = 4'd4,
		CMD_ERASE_RANGE = 4'd5,
		CMD_PUSH_FRONT  = 4'd6,
		CMD_PUSH_BACK   = 4'd7,
		CMD_POP_FRONT   = 4'd8,
		CMD_POP_BACK    = 4'd9,
		CMD_FRONT       = 4'd10,
		CMD_BACK        = 4'd11,
		CMD_CLEAR       = 4'd12
	} cmd_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK    = 2'd0,
		ST_INDEX = 2'd1,
		ST_EMPTY = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SRC,
		S_DST,
		S_FIL,
		S_MOVE,
		S_FILL,
		S_READ,
		S_DONE
	} seq_state_t;

	// one finished result, from the sequencer to the output register
	typedef struct packed {
		logic [VAL_W-1:0]   read_value;
		status_t            status;
		logic [COUNT_W-1:0] item_count;
	} result_t;

endpackage

// File: hdl/ird_if.sv
// ird_if: valid/ready channel interfaces for command words and result words.
// Depends on ird_pkg for field widths.
interface ird_req_if;
	logic                       valid;
	logic                       ready;
	logic [ird_pkg::CMD_W-1:0]  command;
	logic [ird_pkg::IDX_W-1:0]  index;
	logic [ird_pkg::IDX_W-1:0]  end_index;
	logic [ird_pkg::IDX_W-1:0]  gap_count;
	logic [ird_pkg::VAL_W-1:0]  value;

	modport source (output valid, command, index, end_index, gap_count, value, input ready);
	modport sink (input valid, command, index, end_index, gap_count, value, output ready);
endinterface

interface ird_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [ird_pkg::VAL_W-1:0]    read_value;
	logic [ird_pkg::ST_W-1:0]     status;
	logic [ird_pkg::COUNT_W-1:0]  item_count;

	modport source (output valid, read_value, status, item_count, input ready);
	modport sink (input valid, read_value, status, item_count, output ready);
endinterface

// File: hdl/ird_store.sv
// ird_store: single write port, single registered read port ring memory.
// No dependencies.
module ird_store #(
	parameter int DEPTH = 256,
	parameter int DW    = 32,
	parameter int AW    = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// File: hdl/ird_seq.sv
// ird_seq: command decode, shared modulo slot adder and the move/fill sequencer.
// Depends on ird_pkg and ird_if; drives the ird_store ports.
module ird_seq #(
	parameter int CAPACITY   = ird_pkg::CAPACITY_DEF,
	parameter int DATA_WIDTH = ird_pkg::DATA_WIDTH_DEF,
	parameter int AW         = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	ird_req_if.sink                req,
	input  logic                   res_free,
	output logic                   res_load,
	output ird_pkg::result_t       res,
	output logic                   mem_we,
	output logic [AW-1:0]          mem_waddr,
	output logic [DATA_WIDTH-1:0]  mem_wdata,
	output logic [AW-1:0]          mem_raddr,
	input  logic [DATA_WIDTH-1:0]  mem_rdata
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int EW = ((CW > ird_pkg::IDX_W) ? CW : ird_pkg::IDX_W) + 1;
	localparam logic [EW-1:0] CAP_E  = EW'(CAPACITY);
	localparam logic [AW-1:0] LAST_S = AW'(CAPACITY - 1);

	// reduce a sum below twice the capacity to a slot
	function automatic logic [AW-1:0] wrap_slot(input logic [EW-1:0] s);
		logic [EW-1:0] r;
		r = (s >= CAP_E) ? s - CAP_E : s;
		return AW'(r);
	endfunction

	ird_pkg::seq_state_t state_q, state_d;

	logic [AW-1:0]         head_q;
	logic [CW-1:0]         fill_q;
	logic [AW-1:0]         src_q, dst_q, fil_q, hoff_q;
	logic [CW-1:0]         mv_cnt_q, fl_cnt_q, newf_q;
	logic                  up_q, rd_en_q;
	logic [DATA_WIDTH-1:0] fl_word_q;
	ird_pkg::status_t      st_q;
	logic                  pend_s1;
	logic [AW-1:0]         wdst_s1;

	// decoded plan
	logic [AW-1:0]         d_src, d_dst, d_fil, d_hoff;
	logic [CW-1:0]         d_mv, d_flc, d_newf;
	logic                  d_up, d_rd;
	logic [DATA_WIDTH-1:0] d_word;
	ird_pkg::status_t      d_st;

	// operand views
	ird_pkg::cmd_t cmd;
	logic [EW-1:0] f, idx, endi, gap, n_open, last, cn;
	logic          o_front, c_front;
	logic          accept;

	// shared slot adder
	logic [AW-1:0] unit_op, unit_sum;

	assign cmd    = ird_pkg::cmd_t'(req.command);
	assign f      = EW'(fill_q);
	assign idx    = EW'(req.index);
	assign endi   = EW'(req.end_index);
	assign gap    = EW'(req.gap_count);
	assign n_open = (cmd == ird_pkg::CMD_INSERT) ? EW'(1) : gap;
	assign last   = (cmd == ird_pkg::CMD_ERASE) ? idx + EW'(1) : endi;
	assign cn     = last - idx;
	// move the shorter side
	assign o_front = idx < (f >> 1);
	assign c_front = idx < (f - last);

	assign req.ready = (state_q == ird_pkg::S_IDLE);
	assign accept    = req.valid && req.ready;

	// command decode into a move, fill and head plan
	always_comb begin
		d_src  = '0;
		d_dst  = '0;
		d_fil  = '0;
		d_hoff = '0;
		d_mv   = '0;
		d_flc  = '0;
		d_up   = 1'b1;
		d_rd   = 1'b0;
		d_word = DATA_WIDTH'(req.value);
		d_newf = fill_q;
		d_st   = ird_pkg::ST_OK;
		unique case (cmd)
			ird_pkg::CMD_GET: begin
				if (idx >= f) d_st = ird_pkg::ST_INDEX;
				else begin
					d_src = wrap_slot(idx);
					d_rd  = 1'b1;
				end
			end
			ird_pkg::CMD_SET: begin
				if (idx >= f) d_st = ird_pkg::ST_INDEX;
				else begin
					d_fil = wrap_slot(idx);
					d_flc = CW'(1);
				end
			end
			ird_pkg::CMD_INSERT, ird_pkg::CMD_INSERT_GAP: begin
				if (cmd == ird_pkg::CMD_INSERT_GAP) d_word = '0;
				if (idx > f) d_st = ird_pkg::ST_INDEX;
				else if (f + n_open > CAP_E) d_st = ird_pkg::ST_FULL;
				else if (n_open != '0) begin
					d_src  = o_front ? '0 : wrap_slot(f + CAP_E - EW'(1));
					d_dst  = o_front ? wrap_slot(CAP_E - n_open)
						: wrap_slot(f + n_open - EW'(1));
					d_mv   = o_front ? CW'(idx) : CW'(f - idx);
					d_up   = o_front;
					d_fil  = o_front ? wrap_slot(idx + CAP_E - n_open) : wrap_slot(idx);
					d_hoff = o_front ? wrap_slot(CAP_E - n_open) : '0;
					d_flc  = CW'(n_open);
					d_newf = CW'(f + n_open);
				end
			end
			ird_pkg::CMD_ERASE, ird_pkg::CMD_ERASE_RANGE: begin
				if ((cmd == ird_pkg::CMD_ERASE) ? (idx >= f) : (idx > f)) begin
					d_st = ird_pkg::ST_INDEX;
				end else if (last > idx) begin
					if (last > f) d_st = ird_pkg::ST_INDEX;
					else begin
						d_src  = c_front ? wrap_slot(idx + CAP_E - EW'(1)) : wrap_slot(last);
						d_dst  = c_front ? wrap_slot(last + CAP_E - EW'(1)) : wrap_slot(idx);
						d_mv   = c_front ? CW'(idx) : CW'(f - last);
						d_up   = !c_front;
						d_hoff = c_front ? wrap_slot(cn) : '0;
						d_newf = CW'(f - cn);
					end
				end
			end
			ird_pkg::CMD_PUSH_FRONT, ird_pkg::CMD_PUSH_BACK: begin
				if (f >= CAP_E) d_st = ird_pkg::ST_FULL;
				else begin
					d_flc  = CW'(1);
					d_newf = CW'(f + EW'(1));
					if (cmd == ird_pkg::CMD_PUSH_FRONT) begin
						d_hoff = LAST_S;
						d_fil  = LAST_S;
					end else begin
						d_fil = wrap_slot(f);
					end
				end
			end
			ird_pkg::CMD_POP_FRONT, ird_pkg::CMD_POP_BACK: begin
				if (f == '0) d_st = ird_pkg::ST_EMPTY;
				else begin
					d_newf = CW'(f - EW'(1));
					if (cmd == ird_pkg::CMD_POP_FRONT) d_hoff = wrap_slot(EW'(1));
				end
			end
			ird_pkg::CMD_FRONT, ird_pkg::CMD_BACK: begin
				if (f == '0) d_st = ird_pkg::ST_EMPTY;
				else begin
					d_rd  = 1'b1;
					d_src = (cmd == ird_pkg::CMD_FRONT) ? '0 : wrap_slot(f - EW'(1));
				end
			end
			ird_pkg::CMD_CLEAR: begin
				d_newf = '0;
			end
			default: ;
		endcase
	end

	// shared adder: old head plus a logical offset, modulo capacity
	always_comb begin
		unique case (state_q)
			ird_pkg::S_SRC: unit_op = src_q;
			ird_pkg::S_DST: unit_op = dst_q;
			ird_pkg::S_FIL: unit_op = fil_q;
			default:        unit_op = hoff_q;
		endcase
		unit_sum = wrap_slot(EW'(head_q) + EW'(unit_op));
	end

	// next state and result handoff
	always_comb begin
		state_d  = state_q;
		res_load = 1'b0;
		unique case (state_q)
			ird_pkg::S_IDLE: if (accept) state_d = ird_pkg::S_SRC;
			ird_pkg::S_SRC:  state_d = ird_pkg::S_DST;
			ird_pkg::S_DST:  state_d = ird_pkg::S_FIL;
			ird_pkg::S_FIL:  state_d = ird_pkg::S_MOVE;
			ird_pkg::S_MOVE: if (mv_cnt_q == '0) state_d = ird_pkg::S_FILL;
			ird_pkg::S_FILL: begin
				if (fl_cnt_q == '0) state_d = rd_en_q ? ird_pkg::S_READ : ird_pkg::S_DONE;
			end
			ird_pkg::S_READ: state_d = ird_pkg::S_DONE;
			ird_pkg::S_DONE: begin
				if (res_free) begin
					res_load = 1'b1;
					state_d  = ird_pkg::S_IDLE;
				end
			end
			default: state_d = ird_pkg::S_IDLE;
		endcase
	end

	assign res.read_value = rd_en_q ? ird_pkg::VAL_W'(mem_rdata) : '0;
	assign res.status     = st_q;
	assign res.item_count = ird_pkg::COUNT_W'(newf_q);

	// memory ports: move write-back has the port over fill
	assign mem_raddr = src_q;
	assign mem_we    = pend_s1 || ((state_q == ird_pkg::S_FILL) && (fl_cnt_q != '0));
	assign mem_waddr = pend_s1 ? wdst_s1 : fil_q;
	assign mem_wdata = pend_s1 ? mem_rdata : fl_word_q;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ird_pkg::S_IDLE;
			head_q  <= '0;
			fill_q  <= '0;
			pend_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_s1 <= (state_q == ird_pkg::S_MOVE) && (mv_cnt_q != '0);
			if (res_load) begin
				head_q <= unit_sum;
				fill_q <= newf_q;
			end
		end
	end

	// plan registers and slot pointers
	always_ff @(posedge clk) begin
		wdst_s1 <= dst_q;
		if (accept) begin
			src_q     <= d_src;
			dst_q     <= d_dst;
			fil_q     <= d_fil;
			hoff_q    <= d_hoff;
			mv_cnt_q  <= d_mv;
			fl_cnt_q  <= d_flc;
			up_q      <= d_up;
			rd_en_q   <= d_rd;
			fl_word_q <= d_word;
			newf_q    <= d_newf;
			st_q      <= d_st;
		end else begin
			unique case (state_q)
				ird_pkg::S_SRC: src_q <= unit_sum;
				ird_pkg::S_DST: dst_q <= unit_sum;
				ird_pkg::S_FIL: fil_q <= unit_sum;
				ird_pkg::S_MOVE: begin
					if (mv_cnt_q != '0) begin
						mv_cnt_q <= mv_cnt_q - CW'(1);
						if (up_q) begin
							src_q <= (src_q == LAST_S) ? '0 : src_q + AW'(1);
							dst_q <= (dst_q == LAST_S) ? '0 : dst_q + AW'(1);
						end else begin
							src_q <= (src_q == '0) ? LAST_S : src_q - AW'(1);
							dst_q <= (dst_q == '0) ? LAST_S : dst_q - AW'(1);
						end
					end
				end
				ird_pkg::S_FILL: begin
					if (fl_cnt_q != '0) begin
						fl_cnt_q <= fl_cnt_q - CW'(1);
						fil_q    <= (fil_q == LAST_S) ? '0 : fil_q + AW'(1);
					end
				end
				default: ;
			endcase
		end
	end

endmodule

// File: hdl/indexed_ring_deque.sv
// indexed_ring_deque: top level with the sequencer, ring memory and output register.
// Depends on ird_pkg, ird_if, ird_store and ird_seq.
//
// Usage: command words arrive on req (valid/ready), one result word per
// command leaves on rsp (valid/ready). A command is taken only while the
// sequencer is idle; it then runs alone until its result is registered.
// Each command steps through the SRC, DST and FIL states, then MOVE, FILL,
// READ (get, front and back only) and DONE. Indexed insert and erase move
// the shorter side of the list, so up to about CAPACITY/2 moves; insert_gap
// also writes gap_count blank slots. The single memory port pair moves one
// word per cycle.
// Reset clears the head pointer and fill count; slots outside the list are
// never read, so no clearing pass is needed. A stalled receiver holds the
// result in the output register; the next command may be taken meanwhile
// and waits in its final cycle until the register frees.
module indexed_ring_deque #(
	parameter int CAPACITY   = ird_pkg::CAPACITY_DEF,
	parameter int DATA_WIDTH = ird_pkg::DATA_WIDTH_DEF
) (
	input logic      clk,
	input logic      arst_n,
	ird_req_if.sink  req,
	ird_rsp_if.source rsp
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	logic                  res_load, res_free;
	ird_pkg::result_t      res, out_q;
	logic                  ov_q;
	logic                  mem_we;
	logic [AW-1:0]         mem_waddr, mem_raddr;
	logic [DATA_WIDTH-1:0] mem_wdata, mem_rdata;

	ird_seq #(
		.CAPACITY  (CAPACITY),
		.DATA_WIDTH(DATA_WIDTH),
		.AW        (AW)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.res_free (res_free),
		.res_load (res_load),
		.res      (res),
		.mem_we   (mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata)
	);

	ird_store #(
		.DEPTH(CAPACITY),
		.DW   (DATA_WIDTH),
		.AW   (AW)
	) u_store (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// output register: free when empty or being taken
	assign res_free = !ov_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (res_load) begin
			ov_q <= 1'b1;
		end else if (rsp.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			out_q <= res;
		end
	end

	assign rsp.valid      = ov_q;
	assign rsp.read_value = out_q.read_value;
	assign rsp.status     = out_q.status;
	assign rsp.item_count = out_q.item_count;

endmodule

// File: tb/ird_scoreboard.sv
// ird_scoreboard: tracks the deque contents for accepted command words and
// checks each result word against the predicted one. Depends on ird_pkg.

typedef struct packed {
	logic [31:0] read_value;
	logic [1:0]  status;
	logic [8:0]  item_count;
} deque_result_t;

class ird_scoreboard;
	localparam int CAP = 256;
	logic [31:0] slots[CAP];
	int unsigned head;
	int unsigned fill;
	deque_result_t pending[$];
	int errors;

	function new();
		foreach (slots[i]) slots[i] = '0;
		head = 0;
		fill = 0;
		errors = 0;
	endfunction

	function int unsigned pos(int unsigned k);
		return (head + k) % CAP;
	endfunction

	function void blank(int unsigned from, int unsigned n);
		for (int unsigned k = 0; k < n; k++) slots[pos(from + k)] = '0;
	endfunction

	// make room for n words at logical position at, moving the shorter side
	function void open_room(int unsigned at, int unsigned n);
		if (at < fill / 2) begin
			head = (head + CAP - n) % CAP;
			for (int unsigned k = 0; k < at; k++) slots[pos(k)] = slots[pos(k + n)];
		end else begin
			for (int unsigned k = fill; k > at; k--) slots[pos(k - 1 + n)] = slots[pos(k - 1)];
		end
		blank(at, n);
		fill += n;
	endfunction

	function void close_span(int unsigned first, int unsigned last);
		int unsigned n;
		n = last - first;
		if (first < fill - last) begin
			for (int unsigned k = first; k > 0; k--) slots[pos(k - 1 + n)] = slots[pos(k - 1)];
			blank(0, n);
			head = pos(n);
		end else begin
			for (int unsigned k = last; k < fill; k++) slots[pos(k - n)] = slots[pos(k)];
			blank(fill - n, n);
		end
		fill -= n;
	endfunction

	// predict the result word of one accepted command word
	function void note_command(logic [3:0] c, int unsigned idx, int unsigned endi,
			int unsigned gap, logic [31:0] val);
		deque_result_t r;
		ird_pkg::status_t st;
		r.read_value = '0;
		st = ird_pkg::ST_OK;
		case (c)
			ird_pkg::CMD_GET, ird_pkg::CMD_SET: begin
				if (idx >= fill) st = ird_pkg::ST_INDEX;
				else if (c == ird_pkg::CMD_GET) r.read_value = slots[pos(idx)];
				else slots[pos(idx)] = val;
			end
			ird_pkg::CMD_INSERT: begin
				if (idx > fill) st = ird_pkg::ST_INDEX;
				else if (fill >= CAP) st = ird_pkg::ST_FULL;
				else begin
					open_room(idx, 1);
					slots[pos(idx)] = val;
				end
			end
			ird_pkg::CMD_ERASE: begin
				if (idx >= fill) st = ird_pkg::ST_INDEX;
				else close_span(idx, idx + 1);
			end
			ird_pkg::CMD_INSERT_GAP: begin
				if (idx > fill) st = ird_pkg::ST_INDEX;
				else if (fill + gap > CAP) st = ird_pkg::ST_FULL;
				else if (gap > 0) open_room(idx, gap);
			end
			ird_pkg::CMD_ERASE_RANGE: begin
				if (idx > fill) st = ird_pkg::ST_INDEX;
				else if (endi > idx) begin
					if (endi > fill) st = ird_pkg::ST_INDEX;
					else close_span(idx, endi);
				end
			end
			ird_pkg::CMD_PUSH_FRONT, ird_pkg::CMD_PUSH_BACK: begin
				if (fill >= CAP) st = ird_pkg::ST_FULL;
				else if (c == ird_pkg::CMD_PUSH_FRONT) begin
					head = (head + CAP - 1) % CAP;
					slots[head] = val;
					fill++;
				end else begin
					slots[pos(fill)] = val;
					fill++;
				end
			end
			ird_pkg::CMD_POP_FRONT, ird_pkg::CMD_POP_BACK: begin
				if (fill == 0) st = ird_pkg::ST_EMPTY;
				else if (c == ird_pkg::CMD_POP_FRONT) begin
					slots[head] = '0;
					head = pos(1);
					fill--;
				end else begin
					fill--;
					slots[pos(fill)] = '0;
				end
			end
			ird_pkg::CMD_FRONT, ird_pkg::CMD_BACK: begin
				if (fill == 0) st = ird_pkg::ST_EMPTY;
				else r.read_value = slots[pos(c == ird_pkg::CMD_FRONT ? 0 : fill - 1)];
			end
			ird_pkg::CMD_CLEAR: begin
				blank(0, fill);
				fill = 0;
			end
			default: ;
		endcase
		r.status = st;
		r.item_count = fill[8:0];
		pending.push_back(r);
	endfunction

	task report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %0h, expected %0h", what, got, want);
		errors++;
	endtask

	task check_result(logic [31:0] rv, logic [1:0] st, logic [8:0] cnt);
		deque_result_t w;
		if (pending.size() == 0) begin
			report("unexpected word", {21'd0, st, cnt}, 32'd0);
			return;
		end
		w = pending.pop_front();
		if (rv !== w.read_value) report("read_value", rv, w.read_value);
		if (st !== w.status) report("status", {30'd0, st}, {30'd0, w.status});
		if (cnt !== w.item_count) report("item_count", {23'd0, cnt}, {23'd0, w.item_count});
	endtask
endclass

// File: tb/testbench.sv
// testbench: drives command words into indexed_ring_deque under several
// idling phases and checks every result word. Depends on ird_pkg, ird_if,
// ird_scoreboard and the block itself.

module testbench;
	localparam int WATCH_LIMIT = 20000;

	logic clk;
	logic arst_n;
	ird_req_if req ();
	ird_rsp_if rsp ();

	indexed_ring_deque u_dut (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	ird_scoreboard board;
	int send_idle;
	int stall_pct;
	int stuck;
	int n_sent;
	int n_done;
	int cmd_seen[16];

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// accept bookkeeping at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (req.valid && req.ready) begin
				board.note_command(req.command, 32'(req.index), 32'(req.end_index),
					32'(req.gap_count), req.value);
				cmd_seen[req.command]++;
			end
			if (rsp.valid && rsp.ready) begin
				board.check_result(rsp.read_value, rsp.status, rsp.item_count);
				n_done++;
			end
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) stuck <= 0;
			else stuck <= stuck + 1;
		end
	end

	// receiver stalls, decided at the falling edge
	always @(negedge clk) begin
		rsp.ready <= ($urandom_range(99) >= stall_pct);
	end

	// watchdog
	always @(negedge clk) begin
		if (stuck >= WATCH_LIMIT) begin
			$display("watchdog expired");
			$display("testbench NOT OK");
			$finish;
		end
	end

	// send one command word, with optional idle before it
	task send_word(logic [3:0] c, int unsigned idx, int unsigned endi, int unsigned gap,
			logic [31:0] val);
		while ($urandom_range(99) < send_idle) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		req.valid <= 1'b1;
		req.command <= c;
		req.index <= idx[8:0];
		req.end_index <= endi[8:0];
		req.gap_count <= gap[8:0];
		req.value <= val;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		@(negedge clk);
		n_sent++;
	endtask

	// random command mostly aimed at valid positions
	task send_random();
		int unsigned f;
		int unsigned idx;
		int unsigned endi;
		int unsigned gap;
		logic [3:0] c;
		f = board.fill;
		c = 4'($urandom_range(15));
		if ($urandom_range(9) < 2) c = (f < 200) ? ird_pkg::CMD_PUSH_BACK : ird_pkg::CMD_POP_FRONT;
		if ($urandom_range(19) == 0) idx = $urandom_range(511);
		else idx = $urandom_range(f + 1);
		endi = ($urandom_range(9) == 0) ? $urandom_range(511) : idx + $urandom_range(6);
		gap = ($urandom_range(19) == 0) ? $urandom_range(511) : $urandom_range(8);
		// keep clears rare so the list grows deep
		if (c == ird_pkg::CMD_CLEAR && $urandom_range(3) != 0) c = ird_pkg::CMD_INSERT;
		send_word(c, idx, endi, gap, $urandom());
	endtask

	initial begin
		int unsigned tail_wait;
		board = new();
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.command = '0;
		req.index = '0;
		req.end_index = '0;
		req.gap_count = '0;
		req.value = '0;
		rsp.ready = 1'b0;
		send_idle = 0;
		stall_pct = 0;
		stuck = 0;
		n_sent = 0;
		n_done = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty-list faults, extremes, every command
		send_word(ird_pkg::CMD_POP_FRONT, 0, 0, 0, 0);
		send_word(ird_pkg::CMD_BACK, 0, 0, 0, 0);
		send_word(ird_pkg::CMD_ERASE, 0, 0, 0, 0);
		send_word(ird_pkg::CMD_PUSH_BACK, 0, 0, 0, 32'hffff_ffff);
		send_word(ird_pkg::CMD_PUSH_FRONT, 0, 0, 0, 32'h0000_0001);
		send_word(ird_pkg::CMD_INSERT, 1, 0, 0, 32'hdead_beef);
		send_word(ird_pkg::CMD_INSERT, 4, 0, 0, 32'h1);
		send_word(ird_pkg::CMD_GET, 511, 0, 0, 0);
		send_word(ird_pkg::CMD_SET, 2, 0, 0, 32'h5555_aaaa);
		send_word(ird_pkg::CMD_FRONT, 0, 0, 0, 0);
		send_word(ird_pkg::CMD_BACK, 0, 0, 0, 0);
		send_word(ird_pkg::CMD_INSERT_GAP, 1, 0, 0, 0);
		send_word(ird_pkg::CMD_INSERT_GAP, 1, 0, 511, 0);
		send_word(ird_pkg::CMD_INSERT_GAP, 3, 0, 253, 0);
		send_word(ird_pkg::CMD_PUSH_BACK, 0, 0, 0, 32'h7);
		send_word(ird_pkg::CMD_INSERT_GAP, 0, 0, 1, 0);
		send_word(ird_pkg::CMD_ERASE_RANGE, 5, 2, 0, 0);
		send_word(ird_pkg::CMD_ERASE_RANGE, 1, 300, 0, 0);
		send_word(ird_pkg::CMD_ERASE_RANGE, 200, 256, 0, 0);
		send_word(ird_pkg::CMD_ERASE, 1, 0, 0, 0);
		send_word(ird_pkg::CMD_GET, 0, 0, 0, 0);
		send_word(4'd13, 0, 0, 0, 0);
		send_word(4'd15, 511, 511, 511, 32'hffff_ffff);
		send_word(ird_pkg::CMD_POP_BACK, 0, 0, 0, 0);
		send_word(ird_pkg::CMD_CLEAR, 0, 0, 0, 0);

		// random phases with varied idling
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle = 0;  stall_pct = 0;  end
				1: begin send_idle = 85; stall_pct = 0;  end
				2: begin send_idle = 0;  stall_pct = 85; end
				default: begin send_idle = 13; stall_pct = 13; end
			endcase
			repeat (270) send_random();
		end
		send_idle = 0;
		stall_pct = 0;
		req.valid <= 1'b0;

		tail_wait = 0;
		while (board.pending.size() != 0) @(posedge clk);
		while (tail_wait < 400) begin
			@(posedge clk);
			tail_wait++;
		end
		$display("sent %0d command words, checked %0d results", n_sent, n_done);
		$display("push_back %0d insert %0d erase_range %0d insert_gap %0d", cmd_seen[7],
			cmd_seen[2], cmd_seen[5], cmd_seen[4]);
		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end
endmodule
